/* hdl/ptu_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptu_pkg
// Shared types, constants and the CORDIC arctangent table for the point
// transform unit.
// ----------------------------------------------------------------------------
package ptu_pkg;

   // configuration of the datapath
   localparam int CORDIC_STAGES = 16;
   localparam int FRAC_BITS     = 16;
   localparam int ATAN_LEN      = 24;
   localparam int CORDIC_RUN    = (CORDIC_STAGES < ATAN_LEN) ? CORDIC_STAGES : ATAN_LEN;

   // widths
   localparam int CW     = 34;   // CORDIC x/y
   localparam int ZW     = 33;   // CORDIC residual angle
   localparam int SUM_W  = 66;   // sum of two 64-bit products
   localparam int ROT_SHIFT = 30;

   // constants
   localparam logic signed [31:0] RAD_TO_TURN = 32'sd683565276;
   localparam logic signed [CW-1:0] INV_GAIN  = CW'(32'sd652032874);
   localparam logic signed [31:0] TRIG_ONE    = 32'sh4000_0000;

   // operation codes
   localparam logic [2:0] KIND_TRANSLATE = 3'd0;
   localparam logic [2:0] KIND_SCALE     = 3'd1;
   localparam logic [2:0] KIND_ROT_X     = 3'd2;
   localparam logic [2:0] KIND_ROT_Y     = 3'd3;
   localparam logic [2:0] KIND_ROT_Z     = 3'd4;

   typedef struct packed {
      logic [2:0]         kind;
      logic signed [31:0] px;
      logic signed [31:0] py;
      logic signed [31:0] pz;
      logic signed [31:0] dx;
      logic signed [31:0] dy;
      logic signed [31:0] dz;
      logic signed [31:0] factor;
      logic signed [19:0] angle;
   } ptu_req_type;

   typedef struct packed {
      logic signed [31:0] rx;
      logic signed [31:0] ry;
      logic signed [31:0] rz;
      logic               saturated;
   } ptu_rsp_type;

   // operands that ride along with the angle through the trig pipeline
   typedef struct packed {
      logic [2:0]         kind;
      logic signed [31:0] px;
      logic signed [31:0] py;
      logic signed [31:0] pz;
      logic signed [31:0] dx;
      logic signed [31:0] dy;
      logic signed [31:0] dz;
      logic signed [31:0] factor;
   } ptu_carry_type;

   typedef struct packed {
      ptu_carry_type        carry;
      logic [1:0]           quad;
      logic signed [ZW-1:0] resid;
   } ptu_turn_type;

   typedef struct packed {
      ptu_carry_type        carry;
      logic [1:0]           quad;
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic signed [ZW-1:0] z;
   } ptu_rot_type;

   typedef struct packed {
      ptu_carry_type        carry;
      logic [1:0]           quad;
      logic signed [CW-1:0] cx;
      logic signed [CW-1:0] cy;
   } ptu_trig_type;

   // one output coordinate = a*ca + b*cb, rounded
   typedef struct packed {
      logic signed [31:0] a;
      logic signed [31:0] ca;
      logic signed [31:0] b;
      logic signed [31:0] cb;
   } ptu_mac_type;

   // arctangent of 2^-i in binary angle units (2^32 = one turn)
   function automatic logic signed [ZW-1:0] ptu_atan(input int idx);
      logic [31:0] v;
      case (idx)
         0:       v = 32'h2000_0000;
         1:       v = 32'h12E4_051E;
         2:       v = 32'h09FB_385B;
         3:       v = 32'h0511_11D4;
         4:       v = 32'h028B_0D43;
         5:       v = 32'h0145_D7E1;
         6:       v = 32'h00A2_F61E;
         7:       v = 32'h0051_7C55;
         8:       v = 32'h0028_BE53;
         9:       v = 32'h0014_5F2F;
         10:      v = 32'h000A_2F98;
         11:      v = 32'h0005_17CC;
         12:      v = 32'h0002_8BE6;
         13:      v = 32'h0001_45F3;
         14:      v = 32'h0000_A2FA;
         15:      v = 32'h0000_517D;
         16:      v = 32'h0000_28BE;
         17:      v = 32'h0000_145F;
         18:      v = 32'h0000_0A30;
         19:      v = 32'h0000_0518;
         20:      v = 32'h0000_028C;
         21:      v = 32'h0000_0146;
         22:      v = 32'h0000_00A3;
         23:      v = 32'h0000_0051;
         default: v = 32'h0000_0000;
      endcase
      return signed'({1'b0, v});
   endfunction

endpackage

/* hdl/ptu_angle.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptu_angle
// Two-stage front end: radians to binary angle, then quadrant and residual.
// ----------------------------------------------------------------------------
module ptu_angle import ptu_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  ptu_req_type  in_data,
   output logic         out_valid,
   input  logic         out_ready,
   output ptu_turn_type out_data
);

   localparam int PROD_W = 52;

   logic                     prd_v_ff;
   ptu_carry_type            prd_carry_ff;
   logic signed [PROD_W-1:0] prd_ff;
   logic signed [PROD_W-1:0] prd_in;
   logic                     prd_en;

   logic                     trn_v_ff;
   ptu_turn_type             trn_ff;
   ptu_turn_type             trn_in;
   logic                     trn_en;

   logic signed [PROD_W-1:0] rnd_w;
   logic [31:0]              turn_w;
   logic [31:0]              qsum_w;
   logic [31:0]              resid_w;

   assign trn_en   = !trn_v_ff || out_ready;
   assign prd_en   = !prd_v_ff || trn_en;
   assign in_ready = prd_en;

   assign prd_in = PROD_W'(in_data.angle) * PROD_W'(RAD_TO_TURN);

   // round at bit 16, keep binary angle modulo one turn
   always_comb begin
      rnd_w   = prd_ff + PROD_W'(32'sd32768);
      turn_w  = rnd_w[47:16];
      qsum_w  = turn_w + 32'h2000_0000;
      resid_w = turn_w - {qsum_w[31:30], 30'd0};
      trn_in.carry = prd_carry_ff;
      trn_in.quad  = qsum_w[31:30];
      trn_in.resid = ZW'(signed'(resid_w));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prd_v_ff <= 1'b0;
         trn_v_ff <= 1'b0;
      end else begin
         if (prd_en) begin
            prd_v_ff <= in_valid;
         end
         if (trn_en) begin
            trn_v_ff <= prd_v_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (prd_en) begin
         prd_ff       <= prd_in;
         prd_carry_ff <= '{kind:   in_data.kind,
                           px:     in_data.px,
                           py:     in_data.py,
                           pz:     in_data.pz,
                           dx:     in_data.dx,
                           dy:     in_data.dy,
                           dz:     in_data.dz,
                           factor: in_data.factor};
      end
      if (trn_en) begin
         trn_ff <= trn_in;
      end
   end

   assign out_valid = trn_v_ff;
   assign out_data  = trn_ff;

endmodule

/* hdl/ptu_cordic.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptu_cordic
// Rotation-mode CORDIC, one micro-rotation per register stage.
// ----------------------------------------------------------------------------
module ptu_cordic import ptu_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  ptu_turn_type in_data,
   output logic         out_valid,
   input  logic         out_ready,
   output ptu_trig_type out_data
);

   localparam int N = CORDIC_RUN;

   logic        st_v_ff [N];
   ptu_rot_type st_ff   [N];
   ptu_rot_type st_in   [N];
   logic        st_en   [N];

   logic        src_v   [N+1];
   ptu_rot_type src_d   [N+1];
   logic        nxt_rdy [N];

   assign src_v[0]       = in_valid;
   assign src_d[0].carry = in_data.carry;
   assign src_d[0].quad  = in_data.quad;
   assign src_d[0].x     = INV_GAIN;
   assign src_d[0].y     = '0;
   assign src_d[0].z     = in_data.resid;
   assign in_ready       = st_en[0];

   genvar k;
   generate
      for (k = 0; k < N; k++) begin : g_stage
         if (k == N - 1) begin : g_last
            assign nxt_rdy[k] = out_ready;
         end else begin : g_mid
            assign nxt_rdy[k] = st_en[k+1];
         end

         assign st_en[k] = !st_v_ff[k] || nxt_rdy[k];

         always_comb begin
            st_in[k].carry = src_d[k].carry;
            st_in[k].quad  = src_d[k].quad;
            if (!src_d[k].z[ZW-1]) begin
               st_in[k].x = src_d[k].x - (src_d[k].y >>> k);
               st_in[k].y = src_d[k].y + (src_d[k].x >>> k);
               st_in[k].z = src_d[k].z - ptu_atan(k);
            end else begin
               st_in[k].x = src_d[k].x + (src_d[k].y >>> k);
               st_in[k].y = src_d[k].y - (src_d[k].x >>> k);
               st_in[k].z = src_d[k].z + ptu_atan(k);
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               st_v_ff[k] <= 1'b0;
            end else if (st_en[k]) begin
               st_v_ff[k] <= src_v[k];
            end
         end

         always_ff @(posedge clock) begin
            if (st_en[k]) begin
               st_ff[k] <= st_in[k];
            end
         end

         assign src_v[k+1] = st_v_ff[k];
         assign src_d[k+1] = st_ff[k];
      end
   endgenerate

   assign out_valid      = src_v[N];
   assign out_data.carry = src_d[N].carry;
   assign out_data.quad  = src_d[N].quad;
   assign out_data.cx    = src_d[N].x;
   assign out_data.cy    = src_d[N].y;

endmodule

/* hdl/ptu_combine.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptu_combine
// Operand select, multiply, then round and saturate into the output register.
// ----------------------------------------------------------------------------
module ptu_combine import ptu_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  ptu_trig_type in_data,
   output logic         out_valid,
   input  logic         out_ready,
   output ptu_rsp_type  out_data
);

   localparam logic signed [SUM_W-1:0] RND_FRAC = SUM_W'(1) <<< (FRAC_BITS - 1);
   localparam logic signed [SUM_W-1:0] RND_ROT  = SUM_W'(1) <<< (ROT_SHIFT - 1);
   localparam logic signed [SUM_W-1:0] MAX_V    = SUM_W'(32'sh7FFF_FFFF);
   localparam logic signed [SUM_W-1:0] MIN_V    = SUM_W'(32'sh8000_0000);

   // stage 1: operands
   logic                   sel_v_ff;
   ptu_mac_type [2:0]      sel_ff;
   ptu_mac_type [2:0]      sel_in;
   logic                   sel_frac_ff;
   logic                   sel_frac_in;
   logic                   sel_en;

   // stage 2: products
   logic                   mul_v_ff;
   logic signed [63:0]     pa_ff [3];
   logic signed [63:0]     pb_ff [3];
   logic                   mul_frac_ff;
   logic                   mul_en;

   // stage 3: output register
   logic                   rsp_v_ff;
   ptu_rsp_type            rsp_ff;
   ptu_rsp_type            rsp_in;
   logic                   rsp_en;

   logic signed [CW-1:0]   cos_w;
   logic signed [CW-1:0]   sin_w;
   logic signed [31:0]     c_w;
   logic signed [31:0]     s_w;
   logic signed [31:0]     ns_w;
   logic signed [31:0]     pt_w [3];
   logic signed [31:0]     dv_w [3];

   logic signed [SUM_W-1:0] sum_w [3];
   logic signed [SUM_W-1:0] sh_w  [3];
   logic signed [31:0]      res_w [3];
   logic [2:0]              clip_w;

   assign rsp_en   = !rsp_v_ff || out_ready;
   assign mul_en   = !mul_v_ff || rsp_en;
   assign sel_en   = !sel_v_ff || mul_en;
   assign in_ready = sel_en;

   // quadrant fold of the CORDIC result
   always_comb begin
      case (in_data.quad)
         2'd0: begin
            cos_w = in_data.cx;
            sin_w = in_data.cy;
         end
         2'd1: begin
            cos_w = -in_data.cy;
            sin_w = in_data.cx;
         end
         2'd2: begin
            cos_w = -in_data.cx;
            sin_w = -in_data.cy;
         end
         default: begin
            cos_w = in_data.cy;
            sin_w = -in_data.cx;
         end
      endcase
      c_w  = cos_w[31:0];
      s_w  = sin_w[31:0];
      ns_w = -s_w;
   end

   assign pt_w[0] = in_data.carry.px;
   assign pt_w[1] = in_data.carry.py;
   assign pt_w[2] = in_data.carry.pz;
   assign dv_w[0] = in_data.carry.dx;
   assign dv_w[1] = in_data.carry.dy;
   assign dv_w[2] = in_data.carry.dz;

   // untouched coordinates go through as p * 1.0
   always_comb begin
      sel_frac_in = 1'b0;
      for (int o = 0; o < 3; o++) begin
         sel_in[o] = '{a: pt_w[o], ca: TRIG_ONE, b: 32'sd0, cb: 32'sd0};
      end
      case (in_data.carry.kind)
         KIND_TRANSLATE: begin
            for (int o = 0; o < 3; o++) begin
               sel_in[o].b  = dv_w[o];
               sel_in[o].cb = TRIG_ONE;
            end
         end
         KIND_SCALE: begin
            sel_frac_in = 1'b1;
            for (int o = 0; o < 3; o++) begin
               sel_in[o].ca = in_data.carry.factor;
            end
         end
         KIND_ROT_X: begin
            sel_in[1] = '{a: pt_w[1], ca: c_w, b: pt_w[2], cb: ns_w};
            sel_in[2] = '{a: pt_w[1], ca: s_w, b: pt_w[2], cb: c_w};
         end
         KIND_ROT_Y: begin
            sel_in[0] = '{a: pt_w[0], ca: c_w,  b: pt_w[2], cb: s_w};
            sel_in[2] = '{a: pt_w[0], ca: ns_w, b: pt_w[2], cb: c_w};
         end
         KIND_ROT_Z: begin
            sel_in[0] = '{a: pt_w[0], ca: c_w, b: pt_w[1], cb: ns_w};
            sel_in[1] = '{a: pt_w[0], ca: s_w, b: pt_w[1], cb: c_w};
         end
         default: begin
         end
      endcase
   end

   // round half up, floor shift, clip to 32 bits
   always_comb begin
      for (int o = 0; o < 3; o++) begin
         sum_w[o] = SUM_W'(pa_ff[o]) + SUM_W'(pb_ff[o]) + (mul_frac_ff ? RND_FRAC : RND_ROT);
         sh_w[o]  = mul_frac_ff ? (sum_w[o] >>> FRAC_BITS) : (sum_w[o] >>> ROT_SHIFT);
         if (sh_w[o] > MAX_V) begin
            res_w[o]  = MAX_V[31:0];
            clip_w[o] = 1'b1;
         end else if (sh_w[o] < MIN_V) begin
            res_w[o]  = MIN_V[31:0];
            clip_w[o] = 1'b1;
         end else begin
            res_w[o]  = sh_w[o][31:0];
            clip_w[o] = 1'b0;
         end
      end
      rsp_in = '{rx: res_w[0], ry: res_w[1], rz: res_w[2], saturated: |clip_w};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_v_ff <= 1'b0;
         mul_v_ff <= 1'b0;
         rsp_v_ff <= 1'b0;
      end else begin
         if (sel_en) begin
            sel_v_ff <= in_valid;
         end
         if (mul_en) begin
            mul_v_ff <= sel_v_ff;
         end
         if (rsp_en) begin
            rsp_v_ff <= mul_v_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (sel_en) begin
         sel_ff      <= sel_in;
         sel_frac_ff <= sel_frac_in;
      end
      if (mul_en) begin
         for (int o = 0; o < 3; o++) begin
            pa_ff[o] <= 64'(sel_ff[o].a) * 64'(sel_ff[o].ca);
            pb_ff[o] <= 64'(sel_ff[o].b) * 64'(sel_ff[o].cb);
         end
         mul_frac_ff <= sel_frac_ff;
      end
      if (rsp_en) begin
         rsp_ff <= rsp_in;
      end
   end

   assign out_valid = rsp_v_ff;
   assign out_data  = rsp_ff;

endmodule

/* hdl/point_transform_unit_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_transform_unit_top
// Translate, scale or rotate (about X, Y or Z) one Q16.16 3D point per beat.
// ----------------------------------------------------------------------------
// Usage:
//   req_valid/req_ready/req_data carry one beat: operation kind, the point,
//   the translation vector, the scale factor and a Q3.16 radian angle.
//   rsp_valid/rsp_ready/rsp_data return one beat per request, in order:
//   the saturated Q16.16 result and a flag that is set if any coordinate
//   was clipped. Unused kinds return the point unchanged.
// Pipeline: 21 register stages, the first loaded at the accepting edge:
//   2 angle stages (one multiplier stage, one quadrant split), one
//   per CORDIC micro-rotation (16), then operand select, multiply and
//   round/saturate (3). Every operation takes the same path, so results
//   stay in order.
// Throughput: one beat per cycle while rsp_ready is high. Each stage holds
//   a valid bit and advances whenever its successor can take data, so
//   bubbles close up under stall.
// Stall: while rsp_ready is low the output register holds its beat and the
//   stages behind it keep filling; req_ready drops only once every stage
//   holds a beat. Nothing is lost or repeated.
// Reset: synchronous, active high; clears every stage valid bit, so the
//   pipeline is empty and ready on the first cycle after reset.
// ----------------------------------------------------------------------------
module point_transform_unit_top import ptu_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  ptu_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output ptu_rsp_type rsp_data
);

   // angle front end -> CORDIC
   logic         turn_valid;
   logic         turn_ready;
   ptu_turn_type turn_data;

   // CORDIC -> combine
   logic         trig_valid;
   logic         trig_ready;
   ptu_trig_type trig_data;

   ptu_angle u_angle (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (req_data),
      .out_valid (turn_valid),
      .out_ready (turn_ready),
      .out_data  (turn_data)
   );

   ptu_cordic u_cordic (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (turn_valid),
      .in_ready  (turn_ready),
      .in_data   (turn_data),
      .out_valid (trig_valid),
      .out_ready (trig_ready),
      .out_data  (trig_data)
   );

   // also carries translate and scale, so every kind sees the same latency
   ptu_combine u_combine (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (trig_valid),
      .in_ready  (trig_ready),
      .in_data   (trig_data),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_data)
   );

endmodule
